FILE: src/sckm_pkg.sv
// Shared types, keyword table and code values for the serial command keyword matcher.
package sckm_pkg;

   localparam int KEYWORD_COUNT = 5;
   localparam int KEYWORD_MAX   = 8;
   localparam int POS_WIDTH     = 3;
   localparam int SHORT_WIDTH   = 4;

   // Line length clipped to the longest keyword; any longer line maps here.
   localparam logic [SHORT_WIDTH-1:0] SHORT_LONG = 4'hF;

   typedef logic [2:0] command_code_type;
   localparam command_code_type CMD_UNKNOWN  = 3'd0;
   localparam command_code_type CMD_RUN      = 3'd1;
   localparam command_code_type CMD_START    = 3'd2;
   localparam command_code_type CMD_STOP     = 3'd3;
   localparam command_code_type CMD_RESET    = 3'd4;
   localparam command_code_type CMD_TRANSFER = 3'd5;

   typedef logic csr_index_type;
   localparam csr_index_type CSR_END_CODE   = 1'b0;
   localparam csr_index_type CSR_CLEAR_CODE = 1'b1;

   localparam logic [7:0] KW_TEXT [0:KEYWORD_COUNT-1][0:KEYWORD_MAX-1] = '{
      '{"r", "u", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"s", "t", "a", "r", "t", 8'h00, 8'h00, 8'h00},
      '{"s", "t", "o", "p", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"r", "e", "s", "e", "t", 8'h00, 8'h00, 8'h00},
      '{"t", "r", "a", "n", "s", "f", "e", "r"}
   };

   localparam logic [SHORT_WIDTH-1:0] KW_LEN [0:KEYWORD_COUNT-1] = '{
      4'd3, 4'd5, 4'd4, 4'd5, 4'd8
   };

   localparam command_code_type KW_CODE [0:KEYWORD_COUNT-1] = '{
      CMD_RUN, CMD_START, CMD_STOP, CMD_RESET, CMD_TRANSFER
   };

   // Control from the line logic to the keyword tracker for one beat.
   typedef struct packed {
      logic append;   // byte is stored at the current position
      logic restart;  // line ends or is discarded
   } line_ctl_type;

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      if (c >= "A" && c <= "Z") begin
         return c + 8'h20;
      end
      return c;
   endfunction

endpackage

FILE: src/sckm_keyword_tracker.sv
// Running per-keyword match flags and the keyword decode for the current line.
module sckm_keyword_tracker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  sckm_pkg::line_ctl_type               ctl,
   input  logic [7:0]                           rx_byte,
   input  logic [sckm_pkg::SHORT_WIDTH-1:0]     short_count,
   output sckm_pkg::command_code_type           command_code
);

   logic [sckm_pkg::KEYWORD_COUNT-1:0] match_ff;
   logic [sckm_pkg::KEYWORD_COUNT-1:0] match_in;
   logic [7:0]                         folded;
   logic                               pos_ok;
   logic [sckm_pkg::POS_WIDTH-1:0]     pos;

   assign folded = sckm_pkg::fold_case(rx_byte);
   assign pos_ok = short_count < sckm_pkg::SHORT_WIDTH'(sckm_pkg::KEYWORD_MAX);
   assign pos    = short_count[sckm_pkg::POS_WIDTH-1:0];

   always_comb begin
      match_in = match_ff;
      if (ctl.restart) begin
         match_in = '1;
      end else if (ctl.append) begin
         for (int k = 0; k < sckm_pkg::KEYWORD_COUNT; k++) begin
            match_in[k] = match_ff[k] && pos_ok && (folded == sckm_pkg::KW_TEXT[k][pos]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= '1;
      end else begin
         match_ff <= match_in;
      end
   end

   // Scan from the last keyword down so that the first hit in table order wins.
   always_comb begin
      command_code = sckm_pkg::CMD_UNKNOWN;
      for (int k = sckm_pkg::KEYWORD_COUNT - 1; k >= 0; k--) begin
         if (match_ff[k] && (short_count == sckm_pkg::KW_LEN[k])) begin
            command_code = sckm_pkg::KW_CODE[k];
         end
      end
   end

endmodule

FILE: src/serial_command_keyword_matcher.sv
// Top level of the serial command keyword matcher: input stage, line state and result register.
//
// Each received byte is held in the input register while the line logic works on it. A new
// byte is accepted every cycle unless a return byte stalls, for a rate of one byte per clock.
// A command result is registered once its return byte leaves the input stage. The only stall
// comes from the result register: a return byte waits in the input stage while an earlier
// result has not been taken. Letters A to Z match keywords in either case; a line longer than
// LINE_CAPACITY drops the extra bytes and reports unknown with the overflow flag set.
// The match is kept as running flags per keyword, so no line buffer is read at the end.
module serial_command_keyword_matcher #(
   parameter int LINE_CAPACITY = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_rx_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output sckm_pkg::command_code_type rsp_command_code,
   output logic                       rsp_overflowed,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  sckm_pkg::csr_index_type    csr_index,
   input  logic [7:0]                 csr_data
);

   localparam int COUNT_WIDTH = $clog2(LINE_CAPACITY + 1);
   localparam logic [COUNT_WIDTH-1:0] CAP = COUNT_WIDTH'(LINE_CAPACITY);

   logic                             s1_valid_ff, s1_valid_in;
   logic [7:0]                       s1_byte_ff, s1_byte_in;
   logic [COUNT_WIDTH-1:0]           char_count_ff, char_count_in;
   logic                             overflow_ff, overflow_in;
   logic [7:0]                       end_code_ff, end_code_in;
   logic [7:0]                       clear_code_ff, clear_code_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   sckm_pkg::command_code_type       rsp_code_ff, rsp_code_in;
   logic                             rsp_ovf_ff, rsp_ovf_in;

   logic                             is_end, is_clear, s1_go, out_free;
   logic [sckm_pkg::SHORT_WIDTH-1:0] short_count;
   sckm_pkg::line_ctl_type           line_ctl;
   sckm_pkg::command_code_type       kw_code;

   assign is_end   = s1_byte_ff == end_code_ff;
   assign is_clear = !is_end && (s1_byte_ff == clear_code_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign s1_go    = s1_valid_ff && (!is_end || out_free);

   assign req_ready = !s1_valid_ff || s1_go;
   assign csr_ready = 1'b1;

   assign short_count = (char_count_ff > COUNT_WIDTH'(sckm_pkg::KEYWORD_MAX)) ?
                        sckm_pkg::SHORT_LONG : sckm_pkg::SHORT_WIDTH'(char_count_ff);

   assign line_ctl.restart = s1_go && (is_end || is_clear);
   assign line_ctl.append  = s1_go && !is_end && !is_clear && (char_count_ff < CAP);

   sckm_keyword_tracker u_tracker (
      .clock        (clock),
      .reset        (reset),
      .ctl          (line_ctl),
      .rx_byte      (s1_byte_ff),
      .short_count  (short_count),
      .command_code (kw_code)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
         s1_byte_in  = req_rx_byte;
      end

      char_count_in = char_count_ff;
      overflow_in   = overflow_ff;
      if (line_ctl.restart) begin
         char_count_in = '0;
         overflow_in   = 1'b0;
      end else if (line_ctl.append) begin
         char_count_in = char_count_ff + 1'b1;
      end else if (s1_go && !is_end && !is_clear) begin
         overflow_in = 1'b1;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_code_in  = rsp_code_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (s1_go && is_end) begin
         rsp_valid_in = 1'b1;
         rsp_code_in  = overflow_ff ? sckm_pkg::CMD_UNKNOWN : kw_code;
         rsp_ovf_in   = overflow_ff;
      end

      end_code_in   = end_code_ff;
      clear_code_in = clear_code_ff;
      if (csr_valid) begin
         case (csr_index)
            sckm_pkg::CSR_END_CODE: begin
               end_code_in = csr_data;
            end
            sckm_pkg::CSR_CLEAR_CODE: begin
               clear_code_in = csr_data;
            end
            default: begin
               end_code_in = end_code_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         char_count_ff <= '0;
         overflow_ff   <= 1'b0;
         end_code_ff   <= 8'd13;
         clear_code_ff <= 8'd16;
         rsp_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         char_count_ff <= char_count_in;
         overflow_ff   <= overflow_in;
         end_code_ff   <= end_code_in;
         clear_code_ff <= clear_code_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      s1_byte_ff <= s1_byte_in;
      rsp_code_ff <= rsp_code_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_command_code = rsp_code_ff;
   assign rsp_overflowed   = rsp_ovf_ff;

   // Bytes are only dropped once the line is full.
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> (char_count_ff == CAP))
      else $error("overflow flag set on a line that is not full");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      char_count_ff <= CAP)
      else $error("line count beyond capacity");

   a_overflow_unknown: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ovf_ff) |-> (rsp_code_ff == sckm_pkg::CMD_UNKNOWN))
      else $error("overflowed line reported a keyword");

   a_end_stalls: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && is_end && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("return byte passed while the result register was blocked");

   a_line_cleared: assert property (@(posedge clock) disable iff (reset)
      (s1_go && is_end) |=> (char_count_ff == '0) && !overflow_ff && rsp_valid_ff)
      else $error("line not cleared after a result");

endmodule
